// ----- design/pzi_pkg.sv -----
package pzi_pkg;

   localparam int ECHO_WIDTH      = 16;
   localparam int CMP_WIDTH       = (ECHO_WIDTH > 16) ? ECHO_WIDTH : 16;
   localparam int DIST_WIDTH      = 12;
   localparam int DUTY_WIDTH      = 10;
   localparam int LED_WIDTH       = 8;
   localparam int PERIOD_WIDTH    = 8;
   localparam int QUEUE_DEPTH     = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam int NEAR_TICKS      = 1160;
   localparam int FAR_TICKS       = 3480;
   localparam int SPAN_TICKS      = 2320;
   localparam int PERIOD_NEAR     = 31;
   localparam int PERIOD_SPAN     = 224;

   localparam logic [15:0] RED_RELEASE_RESET    = 16'd1392;
   localparam logic [15:0] YELLOW_RELEASE_RESET = 16'd3712;
   localparam logic [9:0]  DUTY_FAR_RESET       = 10'd95;
   localparam logic [9:0]  DUTY_NEAR_RESET      = 10'd645;
   localparam logic [7:0]  PERIOD_HOLD_RESET    = 8'd255;
   localparam logic [7:0]  LED_FULL             = 8'hFF;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RED_RELEASE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_YELLOW_RELEASE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_FAR       = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_NEAR      = 2'd3;

   typedef enum logic [1:0] {
      ZONE_GREEN  = 2'd0,
      ZONE_YELLOW = 2'd1,
      ZONE_RED    = 2'd2
   } zone_code_type;

   typedef struct packed {
      logic [ECHO_WIDTH-1:0] echo_ticks;
      logic                  blink_on;
   } req_type;

   typedef struct packed {
      zone_code_type          zone;
      logic [LED_WIDTH-1:0]   led_red;
      logic [LED_WIDTH-1:0]   led_green;
      logic [LED_WIDTH-1:0]   led_blue;
      logic [PERIOD_WIDTH-1:0] blink_period;
      logic [DUTY_WIDTH-1:0]  servo_duty;
   } rsp_type;

   typedef struct packed {
      logic [15:0]           red_release_ticks;
      logic [15:0]           yellow_release_ticks;
      logic [DUTY_WIDTH-1:0] duty_far;
      logic [DUTY_WIDTH-1:0] duty_near;
   } cfg_type;

   // classified measurement, distance already clamped and offset to the near edge
   typedef struct packed {
      zone_code_type         zone;
      logic [DIST_WIDTH-1:0] offset;
      logic                  blink_on;
   } qent_type;

endpackage

// ----- design/parking_zone_indicator_core.sv -----
// A request is written to the queue, then passes stage 1, stage 2 and the output
// register. Throughput: one request per cycle unless rsp_ready stalls the output; the
// three-stage interpolation pipeline (numerator multiply, reciprocal multiply,
// remainder correction) sets it. A four-entry queue separates classification
// from interpolation. Reset (synchronous, active high): zone green, held blink
// period 255, registers to their defaults, queue and pipeline empty.
module parking_zone_indicator_core #(
   parameter int QUEUE_DEPTH = pzi_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pzi_pkg::req_type                     req_payload,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   output pzi_pkg::rsp_type                     rsp_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pzi_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pzi_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   pzi_pkg::cfg_type  cfg_ff, cfg_in;
   pzi_pkg::qent_type push_data, pop_data;
   logic              push, pop, queue_full, queue_not_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pzi_pkg::CSR_RED_RELEASE:    cfg_in.red_release_ticks    = csr_data;
            pzi_pkg::CSR_YELLOW_RELEASE: cfg_in.yellow_release_ticks = csr_data;
            pzi_pkg::CSR_DUTY_FAR:       cfg_in.duty_far  = csr_data[pzi_pkg::DUTY_WIDTH-1:0];
            pzi_pkg::CSR_DUTY_NEAR:      cfg_in.duty_near = csr_data[pzi_pkg::DUTY_WIDTH-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_release_ticks    <= pzi_pkg::RED_RELEASE_RESET;
         cfg_ff.yellow_release_ticks <= pzi_pkg::YELLOW_RELEASE_RESET;
         cfg_ff.duty_far             <= pzi_pkg::DUTY_FAR_RESET;
         cfg_ff.duty_near            <= pzi_pkg::DUTY_NEAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pzi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .cfg         (cfg_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   pzi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (queue_not_empty)
   );

   pzi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_data      (pop_data),
      .q_valid     (queue_not_empty),
      .q_pop       (pop),
      .cfg         (cfg_ff),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready)
   );

endmodule

// ----- design/pzi_front.sv -----
module pzi_front (
   input  logic              clock,
   input  logic              reset,
   input  pzi_pkg::req_type  req_payload,
   input  logic              req_valid,
   output logic              req_ready,
   input  pzi_pkg::cfg_type  cfg,
   input  logic              queue_full,
   output logic              push,
   output pzi_pkg::qent_type push_data
);

   localparam int CW = pzi_pkg::CMP_WIDTH;

   typedef enum logic [2:0] {
      ST_GREEN  = 3'b001,
      ST_YELLOW = 3'b010,
      ST_RED    = 3'b100
   } zone_state_type;

   zone_state_type zone_ff, zone_in;
   logic [CW-1:0]  t;
   logic [CW-1:0]  near_t, far_t, red_rel, yel_rel, clamped;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign t       = CW'(req_payload.echo_ticks);
   assign near_t  = CW'(pzi_pkg::NEAR_TICKS);
   assign far_t   = CW'(pzi_pkg::FAR_TICKS);
   assign red_rel = CW'(cfg.red_release_ticks);
   assign yel_rel = CW'(cfg.yellow_release_ticks);

   always_comb begin
      case (zone_ff)
         ST_YELLOW: begin
            if (t > near_t && t <= yel_rel) zone_in = ST_YELLOW;
            else if (t <= near_t)           zone_in = ST_RED;
            else                            zone_in = ST_GREEN;
         end
         ST_RED: begin
            if (t <= red_rel)    zone_in = ST_RED;
            else if (t > far_t)  zone_in = ST_GREEN;
            else                 zone_in = ST_YELLOW;
         end
         default: begin
            if (t <= near_t)     zone_in = ST_RED;
            else if (t > far_t)  zone_in = ST_GREEN;
            else                 zone_in = ST_YELLOW;
         end
      endcase
   end

   always_comb begin
      if (t < near_t)     clamped = near_t;
      else if (t > far_t) clamped = far_t;
      else                clamped = t;
   end

   always_comb begin
      case (zone_in)
         ST_YELLOW: push_data.zone = pzi_pkg::ZONE_YELLOW;
         ST_RED:    push_data.zone = pzi_pkg::ZONE_RED;
         default:   push_data.zone = pzi_pkg::ZONE_GREEN;
      endcase
      push_data.offset   = pzi_pkg::DIST_WIDTH'(clamped - near_t);
      push_data.blink_on = req_payload.blink_on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ST_GREEN;
      end else if (push) begin
         zone_ff <= zone_in;
      end
   end

endmodule

// ----- design/pzi_queue.sv -----
module pzi_queue #(
   parameter int DEPTH = pzi_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pzi_pkg::qent_type push_data,
   output logic              full,
   input  logic              pop,
   output pzi_pkg::qent_type pop_data,
   output logic              not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   pzi_pkg::qent_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("request popped from empty queue");
`endif

endmodule

// ----- design/pzi_back.sv -----
module pzi_back (
   input  logic              clock,
   input  logic              reset,
   input  pzi_pkg::qent_type q_data,
   input  logic              q_valid,
   output logic              q_pop,
   input  pzi_pkg::cfg_type  cfg,
   output pzi_pkg::rsp_type  rsp_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready
);

   localparam int DW      = pzi_pkg::DIST_WIDTH;
   localparam int NUMW    = pzi_pkg::DUTY_WIDTH + DW;
   localparam int YW      = NUMW - 4;
   localparam int PNUMW   = 15;
   localparam int DIVISOR = pzi_pkg::SPAN_TICKS / 16;
   localparam int PER_MUL = pzi_pkg::PERIOD_SPAN / 16;
   localparam int RSHIFT  = 24;
   localparam int RECIP   = (1 << RSHIFT) / DIVISOR;
   localparam int RECW    = 17;
   localparam int PRODW   = YW + RECW;
   localparam int QW      = PRODW - RSHIFT;

   // quotient estimate by reciprocal, never more than one below the true value
   function automatic logic [QW-1:0] recip_div(input logic [YW-1:0] y);
      logic [PRODW-1:0] p;
      p = PRODW'(y) * PRODW'(RECIP);
      return p[PRODW-1:RSHIFT];
   endfunction

   function automatic logic [QW-1:0] fix_div(input logic [YW-1:0] y, input logic [QW-1:0] q0);
      logic [YW-1:0] r;
      r = y - YW'(q0) * YW'(DIVISOR);
      return (r >= YW'(DIVISOR)) ? q0 + 1'b1 : q0;
   endfunction

   logic adv1, adv2, adv_out;

   logic                  s1_v_ff, s1_v_in;
   pzi_pkg::zone_code_type s1_zone_ff, s1_zone_in;
   logic                  s1_blink_ff, s1_blink_in;
   logic [YW-1:0]         s1_ydut_ff, s1_ydut_in;
   logic [PNUMW-1:0]      s1_pnum_ff, s1_pnum_in;

   logic                  s2_v_ff, s2_v_in;
   pzi_pkg::zone_code_type s2_zone_ff, s2_zone_in;
   logic                  s2_blink_ff, s2_blink_in;
   logic [YW-1:0]         s2_ydut_ff, s2_ydut_in;
   logic [YW-1:0]         s2_ypnum_ff, s2_ypnum_in;
   logic [QW-1:0]         s2_qd_ff, s2_qd_in;
   logic [QW-1:0]         s2_qp_ff, s2_qp_in;

   logic                  out_v_ff, out_v_in;
   pzi_pkg::rsp_type      out_ff, out_in;
   logic [7:0]            period_hold_ff, period_hold_in;

   logic [DW-1:0]         e;
   logic [NUMW-1:0]       num;
   logic [QW-1:0]         qd, qp;
   logic [7:0]            period_calc;

   assign adv_out = !out_v_ff || rsp_ready;
   assign adv2    = !s2_v_ff || adv_out;
   assign adv1    = !s1_v_ff || adv2;
   assign q_pop   = adv1 && q_valid;

   // stage 1: numerators
   always_comb begin
      e   = DW'(pzi_pkg::SPAN_TICKS) - q_data.offset;
      num = NUMW'(cfg.duty_far) * NUMW'(q_data.offset) + NUMW'(cfg.duty_near) * NUMW'(e);
      s1_v_in     = adv1 ? q_valid : s1_v_ff;
      s1_zone_in  = adv1 ? q_data.zone : s1_zone_ff;
      s1_blink_in = adv1 ? q_data.blink_on : s1_blink_ff;
      s1_ydut_in  = adv1 ? num[NUMW-1:4] : s1_ydut_ff;
      s1_pnum_in  = adv1 ? PNUMW'(q_data.offset) * PNUMW'(PER_MUL) : s1_pnum_ff;
   end

   // stage 2: reciprocal estimate
   always_comb begin
      s2_v_in     = adv2 ? s1_v_ff : s2_v_ff;
      s2_zone_in  = adv2 ? s1_zone_ff : s2_zone_ff;
      s2_blink_in = adv2 ? s1_blink_ff : s2_blink_ff;
      s2_ydut_in  = adv2 ? s1_ydut_ff : s2_ydut_ff;
      s2_ypnum_in = adv2 ? YW'(s1_pnum_ff) : s2_ypnum_ff;
      s2_qd_in    = adv2 ? recip_div(s1_ydut_ff) : s2_qd_ff;
      s2_qp_in    = adv2 ? recip_div(YW'(s1_pnum_ff)) : s2_qp_ff;
   end

   // stage 3: correct quotients, build the result
   always_comb begin
      qd          = fix_div(s2_ydut_ff, s2_qd_ff);
      qp          = fix_div(s2_ypnum_ff, s2_qp_ff);
      period_calc = qp[7:0] + 8'(pzi_pkg::PERIOD_NEAR);

      out_v_in       = adv_out ? s2_v_ff : out_v_ff;
      out_in         = out_ff;
      period_hold_in = period_hold_ff;
      if (adv_out && s2_v_ff) begin
         out_in.zone      = s2_zone_ff;
         out_in.led_blue  = '0;
         out_in.led_red   = '0;
         out_in.led_green = '0;
         case (s2_zone_ff)
            pzi_pkg::ZONE_RED: begin
               out_in.led_red      = pzi_pkg::LED_FULL;
               out_in.blink_period = period_hold_ff;
               out_in.servo_duty   = cfg.duty_near;
            end
            pzi_pkg::ZONE_YELLOW: begin
               if (!s2_blink_ff) begin
                  out_in.led_red   = pzi_pkg::LED_FULL;
                  out_in.led_green = pzi_pkg::LED_FULL;
               end
               out_in.blink_period = period_calc;
               out_in.servo_duty   = pzi_pkg::DUTY_WIDTH'(qd);
               period_hold_in      = period_calc;
            end
            default: begin
               out_in.led_green    = pzi_pkg::LED_FULL;
               out_in.blink_period = period_hold_ff;
               out_in.servo_duty   = cfg.duty_far;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         out_v_ff       <= 1'b0;
         period_hold_ff <= pzi_pkg::PERIOD_HOLD_RESET;
      end else begin
         s1_v_ff        <= s1_v_in;
         s2_v_ff        <= s2_v_in;
         out_v_ff       <= out_v_in;
         period_hold_ff <= period_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_zone_ff  <= s1_zone_in;
      s1_blink_ff <= s1_blink_in;
      s1_ydut_ff  <= s1_ydut_in;
      s1_pnum_ff  <= s1_pnum_in;
      s2_zone_ff  <= s2_zone_in;
      s2_blink_ff <= s2_blink_in;
      s2_ydut_ff  <= s2_ydut_in;
      s2_ypnum_ff <= s2_ypnum_in;
      s2_qd_ff    <= s2_qd_in;
      s2_qp_ff    <= s2_qp_in;
      out_ff      <= out_in;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_yellow_period: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zone == pzi_pkg::ZONE_YELLOW)
         |-> rsp_payload.blink_period >= 8'(pzi_pkg::PERIOD_NEAR))
      else $error("yellow blink period below near value");

   a_yellow_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zone == pzi_pkg::ZONE_YELLOW)
         |-> ((rsp_payload.servo_duty >= cfg.duty_far && rsp_payload.servo_duty <= cfg.duty_near)
           || (rsp_payload.servo_duty >= cfg.duty_near && rsp_payload.servo_duty <= cfg.duty_far)))
      else $error("yellow duty outside the duty range");

   a_blue_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.led_blue == '0)
      else $error("blue channel lit");
`endif

endmodule
